### rtl/ifsa_pkg.sv
`default_nettype none
package ifsa_pkg;

    typedef enum logic [4:0] {
        OP_NOP      = 5'd0,
        OP_ADD      = 5'd1,
        OP_SUB      = 5'd2,
        OP_AND      = 5'd3,
        OP_OR       = 5'd4,
        OP_XOR      = 5'd5,
        OP_NOT      = 5'd6,
        OP_SHL      = 5'd7,
        OP_SHR      = 5'd8,
        OP_ASR      = 5'd9,
        OP_ROR      = 5'd10,
        OP_CLZ      = 5'd11,
        OP_MIN      = 5'd12,
        OP_MAX      = 5'd13,
        OP_MUL_LO24 = 5'd14,
        OP_FADD     = 5'd15,
        OP_FSUB     = 5'd16,
        OP_FMUL     = 5'd17,
        OP_FMIN     = 5'd18,
        OP_FMAX     = 5'd19,
        OP_FMIN_ABS = 5'd20,
        OP_FMAX_ABS = 5'd21,
        OP_FTOI     = 5'd22,
        OP_ITOF     = 5'd23,
        OP_BYTE_ADDS = 5'd24,
        OP_BYTE_SUBS = 5'd25,
        OP_BYTE_MIN  = 5'd26,
        OP_BYTE_MAX  = 5'd27
    } t_op;

    typedef enum logic [1:0] {
        FK_ADD = 2'd0,
        FK_MUL = 2'd1,
        FK_CVT = 2'd2
    } t_fkind;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // normalized value: mant[47] set unless is_zero, exp_b is the biased exponent
    typedef struct packed {
        logic               sign;
        logic signed [10:0] exp_b;
        logic [47:0]        mant;
        logic               is_zero;
    } t_norm;

    function automatic logic [5:0] clz48(input logic [47:0] m);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (m[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    function automatic logic is_nan(input logic [31:0] x);
        return (&x[30:23]) & (|x[22:0]);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return (&x[30:23]) & ~(|x[22:0]);
    endfunction

    // IEEE ordered less-than; false on NaN, -0 equals +0
    function automatic logic flt_lt(input logic [31:0] x, input logic [31:0] y);
        logic res;
        if (is_nan(x) || is_nan(y)) begin
            res = 1'b0;
        end else if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) begin
            res = 1'b0;
        end else if (x[31] != y[31]) begin
            res = x[31];
        end else if (x[31]) begin
            res = x[30:0] > y[30:0];
        end else begin
            res = x[30:0] < y[30:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/ifsa_round.sv
`default_nettype none
module ifsa_round (
    input  wire ifsa_pkg::t_norm i_norm,
    output logic [31:0]          o_word
);

    logic signed [10:0] diff;
    logic signed [10:0] e_adj;
    logic signed [10:0] e_fin;
    logic [5:0]         sh;
    logic [47:0]        mn_s;
    logic               lost;
    logic               up;
    logic [24:0]        rsum;
    logic [23:0]        man;

    always_comb begin
        diff = 11'sd1 - i_norm.exp_b;
        if (i_norm.exp_b < 11'sd1) begin
            e_adj = 11'sd1;
            sh    = (diff > 11'sd48) ? 6'd48 : diff[5:0];
        end else begin
            e_adj = i_norm.exp_b;
            sh    = 6'd0;
        end
        mn_s = i_norm.mant >> sh;
        lost = ((mn_s << sh) != i_norm.mant);
        up   = mn_s[23] & ((|mn_s[22:0]) | lost | mn_s[24]);
        rsum = {1'b0, mn_s[47:24]} + {24'd0, up};
        if (rsum[24]) begin
            man   = rsum[24:1];
            e_fin = e_adj + 11'sd1;
        end else begin
            man   = rsum[23:0];
            e_fin = e_adj;
        end
        if (i_norm.is_zero) begin
            o_word = {i_norm.sign, 31'd0};
        end else if (e_fin >= 11'sd255) begin
            o_word = {i_norm.sign, 8'hFF, 23'd0};
        end else begin
            o_word = {i_norm.sign, (man[23] ? e_fin[7:0] : 8'h00), man[22:0]};
        end
    end

endmodule
`default_nettype wire

### rtl/int_float_simd_alu_top.sv
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | i_req_type, i_operand_a, i_operand_b
// output  | out       | o_valid / i_stall  | o_result_word, o_result_valid
//
// Four register stages (r1 to r4); an accepted beat shows on o_valid once it reaches r4.
// One beat per cycle sustained while the output is not stalled; the 24x24 multiplier
// and the float normalize/round path set the stage depth.
// Synchronous active-low reset clears all stage valid bits.
// A stalled output holds the whole pipeline; o_stall follows i_stall while o_valid.
`default_nettype none
module int_float_simd_alu_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [4:0]  i_req_type,
    input  wire  [31:0] i_operand_a,
    input  wire  [31:0] i_operand_b,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_result_word,
    output logic        o_result_valid
);

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: decode, integer ops, multiply, float unpack
    ifsa_pkg::t_op      op;
    logic [31:0]        a, b;
    logic [4:0]         sh5;
    logic [63:0]        rot;
    logic [31:0]        n1_word;
    logic               n1_rv;
    logic               n1_gen;
    ifsa_pkg::t_fkind   n1_kind;
    logic               n1_mul24;
    logic [23:0]        ma, mb_in;
    logic [7:0]         eea, eeb;
    logic [23:0]        mul_x, mul_y;
    logic [47:0]        n1_prod;
    logic               sbe;
    logic [31:0]        bb;
    logic               swap;
    logic               n1_sign, n1_sub, n1_zsign;
    logic [23:0]        n1_mb, n1_ms;
    logic [7:0]         n1_d;
    logic signed [10:0] n1_base;
    logic [31:0]        n1_abs;
    logic [31:0]        fa_abs, fb_abs;
    logic [7:0]         bx, by;
    logic [8:0]         bs;
    logic [31:0]        vres;
    logic [31:0]        tmag;
    logic [5:0]         lzc;

    always_comb begin
        a   = i_operand_a;
        b   = i_operand_b;
        op  = ifsa_pkg::t_op'(i_req_type);
        sh5 = b[4:0];
        rot = {a, a} >> sh5;
        lzc = ifsa_pkg::clz48({a, 16'h8000});

        ma    = {|a[30:23], a[22:0]};
        mb_in = {|b[30:23], b[22:0]};
        eea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eeb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];

        mul_x   = (op == ifsa_pkg::OP_FMUL) ? ma : a[23:0];
        mul_y   = (op == ifsa_pkg::OP_FMUL) ? mb_in : b[23:0];
        n1_prod = {24'd0, mul_x} * {24'd0, mul_y};

        sbe  = b[31] ^ (op == ifsa_pkg::OP_FSUB);
        bb   = {sbe, b[30:0]};
        swap = b[30:0] > a[30:0];

        vres = '0;
        for (int k = 0; k < 4; k++) begin
            bx = a[8*k +: 8];
            by = b[8*k +: 8];
            bs = {1'b0, bx} + {1'b0, by};
            unique case (op)
                ifsa_pkg::OP_BYTE_ADDS: vres[8*k +: 8] = bs[8] ? 8'hFF : bs[7:0];
                ifsa_pkg::OP_BYTE_SUBS: vres[8*k +: 8] = (bx > by) ? bx - by : 8'd0;
                ifsa_pkg::OP_BYTE_MIN:  vres[8*k +: 8] = (bx < by) ? bx : by;
                default:                vres[8*k +: 8] = (bx > by) ? bx : by;
            endcase
        end

        fa_abs = {1'b0, a[30:0]};
        fb_abs = {1'b0, b[30:0]};

        if (a[30:23] < 8'd127) begin
            tmag = 32'd0;
        end else if (a[30:23] >= 8'd150) begin
            tmag = {8'd0, ma} << (a[30:23] - 8'd150);
        end else begin
            tmag = {8'd0, ma} >> (8'd150 - a[30:23]);
        end

        n1_rv    = 1'b1;
        n1_gen   = 1'b0;
        n1_kind  = ifsa_pkg::FK_ADD;
        n1_mul24 = 1'b0;
        n1_sign  = swap ? sbe : a[31];
        n1_sub   = a[31] ^ sbe;
        n1_zsign = a[31] & sbe;
        n1_mb    = swap ? mb_in : ma;
        n1_ms    = swap ? ma : mb_in;
        n1_d     = swap ? (eeb - eea) : (eea - eeb);
        n1_base  = $signed(11'({3'd0, swap ? eeb : eea})) + 11'sd21;
        n1_abs   = a[31] ? (32'd0 - a) : a;
        n1_word  = '0;

        unique case (op)
            ifsa_pkg::OP_ADD:   n1_word = a + b;
            ifsa_pkg::OP_SUB:   n1_word = a - b;
            ifsa_pkg::OP_AND:   n1_word = a & b;
            ifsa_pkg::OP_OR:    n1_word = a | b;
            ifsa_pkg::OP_XOR:   n1_word = a ^ b;
            ifsa_pkg::OP_NOT:   n1_word = ~a;
            ifsa_pkg::OP_SHL:   n1_word = a << sh5;
            ifsa_pkg::OP_SHR:   n1_word = a >> sh5;
            ifsa_pkg::OP_ASR:   n1_word = $unsigned($signed(a) >>> sh5);
            ifsa_pkg::OP_ROR:   n1_word = rot[31:0];
            ifsa_pkg::OP_CLZ:   n1_word = {26'd0, lzc};
            ifsa_pkg::OP_MIN:   n1_word = ($signed(b) < $signed(a)) ? b : a;
            ifsa_pkg::OP_MAX:   n1_word = ($signed(a) < $signed(b)) ? b : a;
            ifsa_pkg::OP_MUL_LO24: n1_mul24 = 1'b1;
            ifsa_pkg::OP_FADD, ifsa_pkg::OP_FSUB: begin
                n1_kind = ifsa_pkg::FK_ADD;
                if (ifsa_pkg::is_nan(a) || ifsa_pkg::is_nan(b)) begin
                    n1_word = ifsa_pkg::QNAN;
                end else if (ifsa_pkg::is_inf(a) && ifsa_pkg::is_inf(b)
                             && (a[31] != sbe)) begin
                    n1_word = ifsa_pkg::QNAN;
                end else if (ifsa_pkg::is_inf(a)) begin
                    n1_word = a;
                end else if (ifsa_pkg::is_inf(b)) begin
                    n1_word = bb;
                end else begin
                    n1_gen = 1'b1;
                end
            end
            ifsa_pkg::OP_FMUL: begin
                n1_kind = ifsa_pkg::FK_MUL;
                n1_sign = a[31] ^ b[31];
                n1_base = $signed(11'({3'd0, eea}) + 11'({3'd0, eeb})) - 11'sd126;
                if (ifsa_pkg::is_nan(a) || ifsa_pkg::is_nan(b)) begin
                    n1_word = ifsa_pkg::QNAN;
                end else if ((ifsa_pkg::is_inf(a) && (b[30:0] == 31'd0))
                             || (ifsa_pkg::is_inf(b) && (a[30:0] == 31'd0))) begin
                    n1_word = ifsa_pkg::QNAN;
                end else if (ifsa_pkg::is_inf(a) || ifsa_pkg::is_inf(b)) begin
                    n1_word = {a[31] ^ b[31], 8'hFF, 23'd0};
                end else begin
                    n1_gen = 1'b1;
                end
            end
            ifsa_pkg::OP_FMIN:
                n1_word = ifsa_pkg::flt_lt(b, a) ? b : a;
            ifsa_pkg::OP_FMAX:
                n1_word = ifsa_pkg::flt_lt(a, b) ? b : a;
            ifsa_pkg::OP_FMIN_ABS:
                n1_word = ifsa_pkg::flt_lt(fb_abs, fa_abs) ? fb_abs : fa_abs;
            ifsa_pkg::OP_FMAX_ABS:
                n1_word = ifsa_pkg::flt_lt(fa_abs, fb_abs) ? fb_abs : fa_abs;
            ifsa_pkg::OP_FTOI: begin
                if (ifsa_pkg::is_nan(a)) begin
                    n1_word = 32'd0;
                end else if (a[30:23] >= 8'd158) begin
                    n1_word = a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n1_word = a[31] ? (32'd0 - tmag) : tmag;
                end
            end
            ifsa_pkg::OP_ITOF: begin
                n1_kind = ifsa_pkg::FK_CVT;
                n1_gen  = 1'b1;
                n1_sign = a[31];
                n1_base = 11'sd174;
            end
            ifsa_pkg::OP_BYTE_ADDS, ifsa_pkg::OP_BYTE_SUBS,
            ifsa_pkg::OP_BYTE_MIN, ifsa_pkg::OP_BYTE_MAX:
                n1_word = vres;
            default: begin
                n1_word = '0;
                n1_rv   = 1'b0;
            end
        endcase
    end

    logic               r1_v, r1_rv, r1_gen, r1_mul24, r1_sign, r1_sub, r1_zsign;
    ifsa_pkg::t_fkind   r1_kind;
    logic [31:0]        r1_word, r1_abs;
    logic [47:0]        r1_prod;
    logic [23:0]        r1_mb, r1_ms;
    logic [7:0]         r1_d;
    logic signed [10:0] r1_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
        if (en) begin
            r1_rv    <= n1_rv;
            r1_gen   <= n1_gen;
            r1_mul24 <= n1_mul24;
            r1_sign  <= n1_sign;
            r1_sub   <= n1_sub;
            r1_zsign <= n1_zsign;
            r1_kind  <= n1_kind;
            r1_word  <= n1_word;
            r1_abs   <= n1_abs;
            r1_prod  <= n1_prod;
            r1_mb    <= n1_mb;
            r1_ms    <= n1_ms;
            r1_d     <= n1_d;
            r1_base  <= n1_base;
        end
    end

    // stage 2: align and add, select operand for the normalizer
    logic [26:0] big27, sm27, als;
    logic [4:0]  ash;
    logic        stk;
    logic [27:0] sum;
    logic [47:0] n2_m;
    logic        n2_sign;
    logic [31:0] n2_word;

    always_comb begin
        big27 = {r1_mb, 3'b000};
        sm27  = {r1_ms, 3'b000};
        ash   = (r1_d >= 8'd27) ? 5'd27 : r1_d[4:0];
        als   = sm27 >> ash;
        stk   = ((als << ash) != sm27);
        als[0] = als[0] | stk;
        sum   = r1_sub ? ({1'b0, big27} - {1'b0, als}) : ({1'b0, big27} + {1'b0, als});
        n2_word = r1_mul24 ? r1_prod[31:0] : r1_word;
        unique case (r1_kind)
            ifsa_pkg::FK_ADD: begin
                n2_m    = {20'd0, sum};
                n2_sign = (sum == 28'd0) ? r1_zsign : r1_sign;
            end
            ifsa_pkg::FK_MUL: begin
                n2_m    = r1_prod;
                n2_sign = r1_sign;
            end
            ifsa_pkg::FK_CVT: begin
                n2_m    = {16'd0, r1_abs};
                n2_sign = r1_sign;
            end
            default: begin
                n2_m    = '0;
                n2_sign = 1'b0;
            end
        endcase
    end

    logic               r2_v, r2_rv, r2_gen, r2_sign;
    logic [31:0]        r2_word;
    logic [47:0]        r2_m;
    logic signed [10:0] r2_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_rv   <= r1_rv;
            r2_gen  <= r1_gen;
            r2_sign <= n2_sign;
            r2_word <= n2_word;
            r2_m    <= n2_m;
            r2_base <= r1_base;
        end
    end

    // stage 3: leading-zero count and left normalize
    logic [5:0]      lz2;
    ifsa_pkg::t_norm n3_norm;

    always_comb begin
        lz2             = ifsa_pkg::clz48(r2_m);
        n3_norm.sign    = r2_sign;
        n3_norm.mant    = r2_m << lz2;
        n3_norm.exp_b   = r2_base - $signed({5'd0, lz2});
        n3_norm.is_zero = (r2_m == 48'd0);
    end

    logic            r3_v, r3_rv, r3_gen;
    logic [31:0]     r3_word;
    ifsa_pkg::t_norm r3_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_rv   <= r2_rv;
            r3_gen  <= r2_gen;
            r3_word <= r2_word;
            r3_norm <= n3_norm;
        end
    end

    // stage 4: denormal shift, round, result select
    logic [31:0] rnd_word;

    ifsa_round u_round (
        .i_norm (r3_norm),
        .o_word (rnd_word)
    );

    logic        r4_v, r4_rv;
    logic [31:0] r4_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
        if (en) begin
            r4_rv   <= r3_rv;
            r4_word <= r3_gen ? rnd_word : r3_word;
        end
    end

    assign o_valid        = r4_v;
    assign o_result_word  = r4_word;
    assign o_result_valid = r4_rv;

    a_nop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_valid) |-> (o_result_word == 32'd0))
        else $error("nop beat with nonzero word");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !en) |=> r3_v)
        else $error("stage 3 beat lost under stall");

endmodule
`default_nettype wire
